// ===== rtl/bcc_pkg.sv =====
//------------------------------------------------------------------------------
// bcc_pkg
// Shared types for the box/circle contact pipeline.
//------------------------------------------------------------------------------
package bcc_pkg;

	// Payload that travels down the pipeline once the points are known.
	typedef struct packed {
		logic        hit;
		logic        swap;
		logic [33:0] wx;
		logic [33:0] wy;
		logic [33:0] qx;
		logic [33:0] qy;
	} pts_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
	} vec_t;

endpackage

// ===== rtl/box_circle_contact_core.sv =====
//------------------------------------------------------------------------------
// box_circle_contact_core
// Contact manifold between an axis-aligned box and a circle.
//------------------------------------------------------------------------------
// Usage: each input item carries one box and one circle; each accepted item
// gives exactly one result item, in order, with the hit flag, the two contact
// points, the unit normal and the depth. A miss gives an all-zero result.
// The whole datapath is one pipeline that advances when its last stage is
// empty or its result is taken, so one item is accepted every cycle while
// the receiver keeps up. From acceptance to its result, an item passes
// five front stages, the first rescale unit (99 stages: three stages, a
// 32-stage square root and a 64-stage divider), one stage, the second
// rescale unit (99 stages) and the output register. The depth square
// root runs beside the second rescale unit and adds no latency.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated. Reset empties every stage; no clearing pass
// is needed.
//------------------------------------------------------------------------------
module box_circle_contact_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] box_center_x,
	input  logic signed [31:0] box_center_y,
	input  logic [30:0]        box_half_width,
	input  logic [30:0]        box_half_height,
	input  logic [30:0]        box_scale_x,
	input  logic [30:0]        box_scale_y,
	input  logic signed [31:0] circle_center_x,
	input  logic signed [31:0] circle_center_y,
	input  logic [30:0]        circle_radius,
	input  logic [30:0]        circle_major_scale,
	input  logic               circle_first,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] point_a_x,
	output logic signed [31:0] point_a_y,
	output logic signed [31:0] point_b_x,
	output logic signed [31:0] point_b_y,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic [30:0]        depth
);
	localparam logic signed [33:0] SAT = 34'sh7FFFFFFF;
	localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	function automatic logic signed [33:0] sat31(input logic [61:0] p);
		logic [61:0] s;
		s = p >> FRAC_BITS;
		return (s > 62'h7FFFFFFF) ? SAT : 34'($signed({1'b0, s[32:0]}));
	endfunction

	// Stage 1: scaled sizes and centers.
	logic               v_s1, sw_s1;
	logic signed [33:0] bx_s1, by_s1, cx_s1, cy_s1, w_s1, h_s1, r_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bx_s1 <= 34'(box_center_x);
			by_s1 <= 34'(box_center_y);
			cx_s1 <= 34'(circle_center_x);
			cy_s1 <= 34'(circle_center_y);
			w_s1  <= sat31(box_half_width * box_scale_x);
			h_s1  <= sat31(box_half_height * box_scale_y);
			r_s1  <= sat31(circle_radius * circle_major_scale);
			sw_s1 <= circle_first;
		end
	end

	// Stage 2: clamp and inside test.
	logic signed [33:0] dx, dy, kx, ky;
	always_comb begin
		dx = cx_s1 - bx_s1;
		dy = cy_s1 - by_s1;
		kx = (dx < -w_s1) ? -w_s1 : (dx > w_s1) ? w_s1 : dx;
		ky = (dy < -h_s1) ? -h_s1 : (dy > h_s1) ? h_s1 : dy;
	end
	logic               v_s2, sw_s2, in_s2;
	logic signed [33:0] bx_s2, by_s2, cx_s2, cy_s2, w_s2, h_s2, r_s2, kx_s2, ky_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			{bx_s2, by_s2, cx_s2, cy_s2} <= {bx_s1, by_s1, cx_s1, cy_s1};
			{w_s2, h_s2, r_s2, sw_s2}    <= {w_s1, h_s1, r_s1, sw_s1};
			kx_s2 <= kx;
			ky_s2 <= ky;
			in_s2 <= (kx == dx) && (ky == dy);
		end
	end

	// Stage 3: nearest edge when inside, then box point and offset.
	logic signed [33:0] dpx, dnx, dpy, dny, mn, ex, ey, qx, qy;
	always_comb begin
		dpx = w_s2 - kx_s2;
		dnx = kx_s2 + w_s2;
		dpy = h_s2 - ky_s2;
		dny = ky_s2 + h_s2;
		mn  = dpx;
		if (dnx < mn) mn = dnx;
		if (dpy < mn) mn = dpy;
		if (dny < mn) mn = dny;
		ex = kx_s2;
		ey = ky_s2;
		if (in_s2) begin
			if (mn == dpx)      ex = w_s2;
			else if (mn == dnx) ex = -w_s2;
			else if (mn == dpy) ey = h_s2;
			else                ey = -h_s2;
		end
		qx = bx_s2 + ex;
		qy = by_s2 + ey;
	end
	logic               v_s3, sw_s3, in_s3;
	logic signed [33:0] cx_s3, cy_s3, r_s3, qx_s3, qy_s3, vx_s3, vy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			{cx_s3, cy_s3, r_s3, sw_s3, in_s3} <= {cx_s2, cy_s2, r_s2, sw_s2, in_s2};
			qx_s3 <= qx;
			qy_s3 <= qy;
			vx_s3 <= qx - cx_s2;
			vy_s3 <= qy - cy_s2;
		end
	end

	// Stage 4: magnitudes and coarse reach test.
	logic               v_s4, sw_s4, in_s4, near_s4;
	logic signed [33:0] cx_s4, cy_s4, r_s4, qx_s4, qy_s4, vx_s4, vy_s4;
	logic [31:0]        avx_s4, avy_s4;
	logic [33:0]        avx, avy;
	assign avx = vx_s3[33] ? 34'(-vx_s3) : 34'(vx_s3);
	assign avy = vy_s3[33] ? 34'(-vy_s3) : 34'(vy_s3);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			{cx_s4, cy_s4, r_s4, sw_s4, in_s4} <= {cx_s3, cy_s3, r_s3, sw_s3, in_s3};
			{qx_s4, qy_s4, vx_s4, vy_s4} <= {qx_s3, qy_s3, vx_s3, vy_s3};
			near_s4 <= ($signed(avx) < r_s3) && ($signed(avy) < r_s3);
			avx_s4  <= avx[31:0];
			avy_s4  <= avy[31:0];
		end
	end

	// Stage 5: squares.
	logic               v_s5, sw_s5, in_s5, near_s5;
	logic signed [33:0] cx_s5, cy_s5, r_s5, qx_s5, qy_s5, vx_s5, vy_s5;
	logic [63:0]        sx_s5, sy_s5, sr_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			{cx_s5, cy_s5, r_s5, sw_s5, in_s5, near_s5} <=
				{cx_s4, cy_s4, r_s4, sw_s4, in_s4, near_s4};
			{qx_s5, qy_s5, vx_s5, vy_s5} <= {qx_s4, qy_s4, vx_s4, vy_s4};
			sx_s5 <= avx_s4 * avx_s4;
			sy_s5 <= avy_s4 * avy_s4;
			sr_s5 <= r_s4[31:0] * r_s4[31:0];
		end
	end

	// Stage 6: final hit decision.
	logic               hit6;
	assign hit6 = in_s5 || (near_s5 && ({1'b0, sx_s5} + {1'b0, sy_s5} < {1'b0, sr_s5}));

	localparam int S1_W = 1 + 1 + 1 + 4 * 34;
	logic              r1_v;
	bcc_pkg::vec_t     r1_v_out;
	logic [S1_W-1:0]   r1_side;
	logic              h_a, sw_a, in_a;
	logic signed [33:0] cx_a, cy_a, qx_a, qy_a;
	bcc_rescale #(.SIDE_W(S1_W)) u_rs_circle (
		.clk, .arst_n, .en,
		.in_valid (v_s5),
		.in_v     ('{x: vx_s5, y: vy_s5}),
		.in_m     (r_s5[31:0]),
		.in_side  ({hit6, sw_s5, in_s5, cx_s5, cy_s5, qx_s5, qy_s5}),
		.out_valid(r1_v),
		.out_v    (r1_v_out),
		.out_side (r1_side)
	);
	assign {h_a, sw_a, in_a, cx_a, cy_a, qx_a, qy_a} = r1_side;

	// Circle point and offset to the box point.
	logic signed [33:0] ax, ay, wx, wy;
	assign ax = in_a ? -r1_v_out.x : r1_v_out.x;
	assign ay = in_a ? -r1_v_out.y : r1_v_out.y;
	assign wx = cx_a + ax;
	assign wy = cy_a + ay;

	logic               v_b;
	bcc_pkg::pts_t      p_b;
	logic signed [33:0] fx_b, fy_b;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_b <= 1'b0;
		else if (en) v_b <= r1_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_b  <= '{hit: h_a, swap: sw_a, wx: wx, wy: wy, qx: qx_a, qy: qy_a};
			fx_b <= qx_a - wx;
			fy_b <= qy_a - wy;
		end
	end

	// The normal and the depth run side by side.
	localparam int S2_W = $bits(bcc_pkg::pts_t);
	logic          r2_v;
	bcc_pkg::vec_t nrm;
	logic [S2_W-1:0] r2_side;
	bcc_rescale #(.SIDE_W(S2_W)) u_rs_normal (
		.clk, .arst_n, .en,
		.in_valid (v_b),
		.in_v     ('{x: fx_b, y: fy_b}),
		.in_m     (ONE[31:0]),
		.in_side  (p_b),
		.out_valid(r2_v),
		.out_v    (nrm),
		.out_side (r2_side)
	);

	logic [33:0] afx, afy;
	logic        big;
	assign afx = fx_b[33] ? 34'(-fx_b) : 34'(fx_b);
	assign afy = fy_b[33] ? 34'(-fy_b) : 34'(fy_b);
	assign big = afx >= 34'h80000000 || afy >= 34'h80000000;

	logic [31:0] afx_c, afy_c;
	logic        big_c;
	logic        v_c;
	logic [63:0] sq_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_c <= 1'b0;
		else if (en) v_c <= v_b;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			afx_c <= afx[31:0];
			afy_c <= afy[31:0];
			big_c <= big;
		end
	end
	logic [63:0] sqx_d, sqy_d;
	logic        v_d, big_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d <= 1'b0;
		else if (en) v_d <= v_c;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_d <= afx_c * afx_c;
			sqy_d <= afy_c * afy_c;
			big_d <= big_c;
		end
	end
	logic v_e, big_e;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_e <= 1'b0;
		else if (en) v_e <= v_d;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_c  <= sqx_d + sqy_d;
			big_e <= big_d;
		end
	end
	logic        dq_v;
	logic [31:0] droot;
	logic        dq_big;
	bcc_sqrt #(.IN_W(64), .SIDE_W(1)) u_depth (
		.clk, .arst_n, .en,
		.in_valid (v_e),
		.in_n     (sq_c),
		.in_side  (big_e),
		.out_valid(dq_v),
		.out_root (droot),
		.out_side (dq_big)
	);

	// Align the depth with the normal: the rescale path takes 99 stages and
	// the depth path 35, so the depth and its valid bit go through a 64-stage
	// delay line.
	localparam int DLY = 64;
	logic [32:0] dl_s [DLY+1];
	assign dl_s[0] = {dq_v,
		(dq_big || droot > 32'h7FFFFFFF) ? 32'h7FFFFFFF : droot};
	for (genvar g = 0; g < DLY; g++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) dl_s[g+1] <= dl_s[g];
		end
	end

	bcc_pkg::pts_t p_o;
	assign p_o = r2_side;

	function automatic logic [31:0] pt32(input logic signed [33:0] v);
		if (v > 34'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (v < -34'sh80000000) return 32'h80000000;
		return v[31:0];
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= r2_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hit <= p_o.hit;
			if (!p_o.hit) begin
				{point_a_x, point_a_y, point_b_x, point_b_y} <= '0;
				{normal_x, normal_y, depth} <= '0;
			end else begin
				point_a_x <= pt32(p_o.swap ? p_o.qx : p_o.wx);
				point_a_y <= pt32(p_o.swap ? p_o.qy : p_o.wy);
				point_b_x <= pt32(p_o.swap ? p_o.wx : p_o.qx);
				point_b_y <= pt32(p_o.swap ? p_o.wy : p_o.qy);
				normal_x  <= p_o.swap ? 18'(-nrm.x) : 18'(nrm.x);
				normal_y  <= p_o.swap ? 18'(-nrm.y) : 18'(nrm.y);
				depth     <= dl_s[DLY][30:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_a_x))
		else $error("result changed while stalled");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> depth == 0 && normal_x == 0 && normal_y == 0)
		else $error("miss with nonzero fields");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline stalled with empty output");
	a_depth_align: assert property (@(posedge clk) disable iff (!arst_n)
		r2_v |-> dl_s[DLY][32])
		else $error("depth not aligned with the normal");
`endif
endmodule

// ===== rtl/bcc_sqrt.sv =====
//------------------------------------------------------------------------------
// bcc_sqrt
// Pipelined floor square root, one result bit per stage, with a side band
// that travels alongside the operand.
//------------------------------------------------------------------------------
module bcc_sqrt #(
	parameter int IN_W   = 64,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     in_n,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]   out_side
);
	localparam int STAGES = IN_W / 2;

	logic [IN_W-1:0]   rem_s  [STAGES+1];
	logic [IN_W/2-1:0] root_s [STAGES+1];
	logic [SIDE_W-1:0] side_s [STAGES+1];
	logic              vld_s  [STAGES+1];

	assign rem_s[0]  = in_n;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		localparam int SH = IN_W - 2 - 2 * g;
		logic [IN_W+1:0] trial;
		logic            take;
		always_comb begin
			trial = ({2'b0, rem_s[g]} >> SH) -
				{{(IN_W/2){1'b0}}, root_s[g], 2'b01};
			take  = !trial[IN_W+1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				root_s[g+1] <= {root_s[g][IN_W/2-2:0], take};
				if (take)
					rem_s[g+1] <= rem_s[g] - ({{(IN_W/2-2){1'b0}}, root_s[g], 2'b01} << SH);
				else
					rem_s[g+1] <= rem_s[g];
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_root  = root_s[STAGES];
	assign out_side  = side_s[STAGES];
endmodule

// ===== rtl/bcc_div.sv =====
//------------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider for magnitudes, one quotient bit per stage,
// with a side band that travels alongside the operands.
//------------------------------------------------------------------------------
module bcc_div #(
	parameter int NUM_W  = 64,
	parameter int DEN_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);
	logic [NUM_W-1:0]  num_s  [NUM_W+1];
	logic [DEN_W-1:0]  den_s  [NUM_W+1];
	logic [DEN_W:0]    rem_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];
	logic              vld_s  [NUM_W+1];

	assign num_s[0]  = in_num;
	assign den_s[0]  = in_den;
	assign rem_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] diff;
		always_comb begin
			sh   = {rem_s[g], num_s[g][NUM_W-1]};
			diff = sh - {2'b0, den_s[g]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				den_s[g+1]  <= den_s[g];
				if (!diff[DEN_W+1]) begin
					rem_s[g+1] <= diff[DEN_W:0];
					num_s[g+1] <= {num_s[g][NUM_W-2:0], 1'b1};
				end else begin
					rem_s[g+1] <= sh[DEN_W:0];
					num_s[g+1] <= {num_s[g][NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign out_quo   = num_s[NUM_W];
	assign out_side  = side_s[NUM_W];
endmodule

// ===== rtl/bcc_rescale.sv =====
//------------------------------------------------------------------------------
// bcc_rescale
// Rescales a vector to a given length: halving, square root of the squared
// length, then one division per component, all pipelined.
//------------------------------------------------------------------------------
module bcc_rescale #(
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  bcc_pkg::vec_t       in_v,
	input  logic [31:0]         in_m,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output bcc_pkg::vec_t       out_v,
	output logic [SIDE_W-1:0]   out_side
);
	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_X    = 2'd1;
	localparam logic [1:0] KIND_Y    = 2'd2;
	localparam logic [1:0] KIND_GEN  = 2'd3;

	// Stage 1: halve toward zero until both components fit in 31 bits.
	logic signed [33:0] hx, hy;
	always_comb begin
		hx = in_v.x;
		hy = in_v.y;
		for (int i = 0; i < 3; i++) begin
			if (hx >= 34'sh80000000 || hx <= -34'sh80000000 ||
			    hy >= 34'sh80000000 || hy <= -34'sh80000000) begin
				hx = hx / 2;
				hy = hy / 2;
			end
		end
	end

	typedef struct packed {
		logic [1:0]         kind;   // zero vector, on x axis, on y axis, general
		logic               sx;
		logic               sy;
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic [31:0]        m;
		logic [SIDE_W-1:0]  side;
	} rs_t;

	rs_t         r_s1;
	logic        v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1.kind <= (in_v.x == 0 && in_v.y == 0) ? KIND_ZERO :
				(in_v.y == 0) ? KIND_X : (in_v.x == 0) ? KIND_Y : KIND_GEN;
			r_s1.sx   <= in_v.x < 0;
			r_s1.sy   <= in_v.y < 0;
			r_s1.ax   <= hx[33] ? 32'(-hx) : 32'(hx);
			r_s1.ay   <= hy[33] ? 32'(-hy) : 32'(hy);
			r_s1.m    <= in_m;
			r_s1.side <= in_side;
		end
	end

	// Stage 2: squares.
	rs_t         r_s2;
	logic        v_s2;
	logic [63:0] sqx_s2, sqy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s2   <= r_s1;
			sqx_s2 <= r_s1.ax * r_s1.ax;
			sqy_s2 <= r_s1.ay * r_s1.ay;
		end
	end

	// Stage 3: products with the length, squared sum for the root.
	rs_t         r_s3;
	logic        v_s3;
	logic [63:0] sum_s3, px_s3, py_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= r_s2;
			sum_s3 <= sqx_s2 + sqy_s2;
			px_s3  <= r_s2.ax * r_s2.m;
			py_s3  <= r_s2.ay * r_s2.m;
		end
	end

	localparam int SQ_SIDE = $bits(rs_t) + 128;
	logic               sq_v;
	logic [31:0]        sq_root;
	logic [SQ_SIDE-1:0] sq_side;
	bcc_sqrt #(.IN_W(64), .SIDE_W(SQ_SIDE)) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (v_s3),
		.in_n     (sum_s3),
		.in_side  ({r_s3, px_s3, py_s3}),
		.out_valid(sq_v),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	rs_t         r_q;
	logic [63:0] px_q, py_q;
	assign {r_q, px_q, py_q} = sq_side;

	// Each component has its own divider rather than one divider for a
	// 128-bit pair; the two dividers run side by side.
	localparam int DV_SIDE = $bits(rs_t);
	logic               dx_v, dy_v;
	logic [63:0]        qx, qy;
	logic [DV_SIDE-1:0] dx_side;
	logic               zlen;
	logic [31:0]        den;
	assign den = (sq_root == 0) ? 32'd1 : sq_root;

	bcc_div #(.NUM_W(64), .DEN_W(32), .SIDE_W(DV_SIDE)) u_divx (
		.clk, .arst_n, .en,
		.in_valid (sq_v),
		.in_num   (px_q),
		.in_den   (den),
		.in_side  (r_q),
		.out_valid(dx_v),
		.out_quo  (qx),
		.out_side (dx_side)
	);
	bcc_div #(.NUM_W(64), .DEN_W(32), .SIDE_W(1)) u_divy (
		.clk, .arst_n, .en,
		.in_valid (sq_v),
		.in_num   (py_q),
		.in_den   (den),
		.in_side  (sq_root == 0),
		.out_valid(dy_v),
		.out_quo  (qy),
		.out_side (zlen)
	);

	rs_t  r_o;
	assign r_o = dx_side;

	logic signed [33:0] mx, ox, oy;
	always_comb begin
		mx = 34'($signed({2'b0, r_o.m}));
		ox = '0;
		oy = '0;
		case (r_o.kind)
			KIND_X: ox = r_o.sx ? -mx : mx;
			KIND_Y: oy = r_o.sy ? -mx : mx;
			KIND_GEN: begin
				if (!zlen) begin
					ox = r_o.sx ? -34'(qx) : 34'(qx);
					oy = r_o.sy ? -34'(qy) : 34'(qy);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = dx_v & dy_v;
	assign out_v.x   = ox;
	assign out_v.y   = oy;
	assign out_side  = r_o.side;
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Box/circle contact testbench
// Streams box and circle pairs through the contact pipeline under random
// sender and receiver idling, predicts each manifold in the testbench and
// checks every result field in order.
//------------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic signed [31:0] bx, by, cx, cy;
		logic [30:0]        hw, hh, sx, sy, rad, rs;
		logic               cf;
	} pair_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] ax, ay, bx, by;
		logic signed [17:0] nx, ny;
		logic [30:0]        dep;
	} manifold_t;

	localparam int          FRAC      = 16;
	localparam longint      SAT31     = 64'h7FFF_FFFF;
	localparam longint      LIM31     = 64'h8000_0000;
	localparam int          LATENCY   = 300;
	localparam longint      MAX_CYCLE = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
	logic signed [31:0] box_center_x = '0, box_center_y = '0;
	logic signed [31:0] circle_center_x = '0, circle_center_y = '0;
	logic [30:0] box_half_width = '0, box_half_height = '0, box_scale_x = '0;
	logic [30:0] box_scale_y = '0, circle_radius = '0, circle_major_scale = '0;
	logic circle_first = 1'b0;
	logic hit;
	logic signed [31:0] point_a_x, point_a_y, point_b_x, point_b_y;
	logic signed [17:0] normal_x, normal_y;
	logic [30:0] depth;

	pair_t     pending_pairs[$];
	manifold_t expected_manifolds[$];
	int        send_idle_pct = 14, recv_idle_pct = 81;
	bit        failed = 1'b0;
	longint    cycle = 0;

	box_circle_contact_core u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint abs_l(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint scale_q(logic [30:0] a, logic [30:0] s);
		longint unsigned p;
		p = (longint'(a) * longint'(s)) >> FRAC;
		return p > SAT31 ? SAT31 : longint'(p);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic set_length(input longint x, input longint y, input longint m,
			output longint ox, output longint oy);
		longint len;
		ox = 0;
		oy = 0;
		if (x == 0 && y == 0) return;
		if (y == 0) begin
			ox = x > 0 ? m : -m;
			return;
		end
		if (x == 0) begin
			oy = y > 0 ? m : -m;
			return;
		end
		while (abs_l(x) >= LIM31 || abs_l(y) >= LIM31) begin
			x /= 2;
			y /= 2;
		end
		len = longint'(floor_sqrt(longint'(x * x) + longint'(y * y)));
		if (len == 0) return;
		ox = x * m / len;
		oy = y * m / len;
	endtask

	task automatic predict_contact(input pair_t p, output manifold_t e);
		longint bx, by, cx, cy, sw, sh, r, dx, dy, kx, ky, qx, qy, vx, vy;
		longint ax, ay, wx, wy, fx, fy, nx, ny, dep, mn, dpx, dnx, dpy, dny, t;
		longint unsigned d2, r2;
		bit in_box;
		e = '{default: '0};
		bx = p.bx; by = p.by; cx = p.cx; cy = p.cy;
		sw = scale_q(p.hw, p.sx);
		sh = scale_q(p.hh, p.sy);
		r = scale_q(p.rad, p.rs);
		dx = cx - bx;
		dy = cy - by;
		kx = clampl(dx, -sw, sw);
		ky = clampl(dy, -sh, sh);
		in_box = (kx == dx) && (ky == dy);
		if (in_box) begin
			dpx = sw - kx; dnx = kx + sw; dpy = sh - ky; dny = ky + sh;
			mn = dpx;
			if (dnx < mn) mn = dnx;
			if (dpy < mn) mn = dpy;
			if (dny < mn) mn = dny;
			if (mn == dpx) kx = sw;
			else if (mn == dnx) kx = -sw;
			else if (mn == dpy) ky = sh;
			else ky = -sh;
		end
		qx = bx + kx;
		qy = by + ky;
		vx = qx - cx;
		vy = qy - cy;
		if (!in_box) begin
			if (abs_l(vx) >= r || abs_l(vy) >= r) return;
			d2 = longint'(vx * vx) + longint'(vy * vy);
			r2 = longint'(r * r);
			if (d2 >= r2) return;
		end
		set_length(vx, vy, r, ax, ay);
		if (in_box) begin
			ax = -ax;
			ay = -ay;
		end
		wx = cx + ax;
		wy = cy + ay;
		fx = qx - wx;
		fy = qy - wy;
		set_length(fx, fy, longint'(1) << FRAC, nx, ny);
		if (abs_l(fx) >= LIM31 || abs_l(fy) >= LIM31) dep = SAT31;
		else begin
			dep = longint'(floor_sqrt(longint'(fx * fx) + longint'(fy * fy)));
			if (dep > SAT31) dep = SAT31;
		end
		if (p.cf) begin
			t = wx; wx = qx; qx = t;
			t = wy; wy = qy; qy = t;
			nx = -nx;
			ny = -ny;
		end
		e.hit = 1'b1;
		e.ax = 32'(clampl(wx, -LIM31, LIM31 - 1));
		e.ay = 32'(clampl(wy, -LIM31, LIM31 - 1));
		e.bx = 32'(clampl(qx, -LIM31, LIM31 - 1));
		e.by = 32'(clampl(qy, -LIM31, LIM31 - 1));
		e.nx = nx[17:0];
		e.ny = ny[17:0];
		e.dep = dep[30:0];
	endtask

	function automatic logic [30:0] rand31();
		case ($urandom_range(0, 5))
			0: return 31'h7FFF_FFFF;
			1: return '0;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, 32'h000F_FFFF));
		endcase
	endfunction

	task automatic queue_pair(input pair_t p);
		manifold_t e;
		pending_pairs.push_back(p);
		predict_contact(p, e);
		expected_manifolds.push_back(e);
	endtask

	// Mostly near-contact geometry with unit-ish scales, plus raw noise.
	function automatic pair_t random_pair();
		pair_t p;
		p.bx = $urandom;
		p.by = $urandom;
		p.cf = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 8) begin
			p.hw = 31'($urandom_range(0, 32'h0040_0000));
			p.hh = 31'($urandom_range(0, 32'h0040_0000));
			p.sx = 31'($urandom_range(32'h0000_8000, 32'h0002_0000));
			p.sy = 31'($urandom_range(32'h0000_8000, 32'h0002_0000));
			p.rad = 31'($urandom_range(0, 32'h0040_0000));
			p.rs = 31'($urandom_range(32'h0000_8000, 32'h0002_0000));
			p.bx = $signed($urandom) >>> $urandom_range(0, 8);
			p.by = $signed($urandom) >>> $urandom_range(0, 8);
			p.cx = p.bx + ($signed($urandom) >>> $urandom_range(8, 12));
			p.cy = p.by + ($signed($urandom) >>> $urandom_range(8, 12));
		end else begin
			p.hw = rand31(); p.hh = rand31(); p.sx = rand31(); p.sy = rand31();
			p.rad = rand31(); p.rs = rand31();
			p.cx = $urandom;
			p.cy = $urandom;
		end
		return p;
	endfunction

	initial begin
		pair_t p;
		int    n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// Directed pairs: field extremes, each inside edge, edges exactly hit.
		p = '{bx: 0, by: 0, cx: 0, cy: 0, hw: 31'h10000, hh: 31'h10000,
			sx: 31'h10000, sy: 31'h10000, rad: 31'h8000, rs: 31'h10000, cf: 1'b0};
		queue_pair(p);
		p.cx = 32'h8000; queue_pair(p);
		p.cx = -32'sh8000; queue_pair(p);
		p.cx = 0; p.cy = 32'h8000; queue_pair(p);
		p.cy = -32'sh8000; queue_pair(p);
		p.cy = 0; p.cx = 32'h10000; queue_pair(p);
		p.cx = 32'h18000; p.cf = 1'b1; queue_pair(p);
		p.cx = 32'h18000; p.cy = 32'h18000; queue_pair(p);
		p.cx = 32'h20000; p.cy = 0; queue_pair(p);
		p.rad = '0; p.cx = 32'h18000; queue_pair(p);
		p.cx = 32'h14000; p.cy = 32'h14000; p.rad = 31'h10000; p.cf = 1'b0;
		queue_pair(p);
		p = '{bx: 32'h7FFF_FFFF, by: 32'h8000_0000, cx: 32'h8000_0000,
			cy: 32'h7FFF_FFFF, hw: '1, hh: '1, sx: '1, sy: '1, rad: '1, rs: '1,
			cf: 1'b1};
		queue_pair(p);
		p.cf = 1'b0; p.sx = '0; p.sy = '0; queue_pair(p);
		p.bx = 32'h8000_0000; p.cx = 32'h7FFF_FFFF; p.hw = '0; p.hh = '0;
		queue_pair(p);
		p = '{bx: 0, by: 0, cx: 0, cy: 0, hw: '0, hh: '0, sx: '0, sy: '0,
			rad: '0, rs: '0, cf: 1'b0};
		queue_pair(p);
		p.rad = '1; p.rs = 31'h10000; p.cx = 32'h0001_0000; queue_pair(p);
		for (n = 0; n < 750; n++) begin
			if (n == 250) begin
				wait (pending_pairs.size() == 0);
				send_idle_pct = 81;
				recv_idle_pct = 14;
			end
			if (n == 500) begin
				wait (pending_pairs.size() == 0);
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_pair(random_pair());
		end
		wait (pending_pairs.size() == 0 && expected_manifolds.size() == 0);
		repeat (LATENCY) @(posedge clk);
		if (!failed) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Driver: valid stays up with a frozen payload until accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid) void'(pending_pairs.pop_front());
				if (pending_pairs.size() > 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					box_center_x <= pending_pairs[0].bx;
					box_center_y <= pending_pairs[0].by;
					box_half_width <= pending_pairs[0].hw;
					box_half_height <= pending_pairs[0].hh;
					box_scale_x <= pending_pairs[0].sx;
					box_scale_y <= pending_pairs[0].sy;
					circle_center_x <= pending_pairs[0].cx;
					circle_center_y <= pending_pairs[0].cy;
					circle_radius <= pending_pairs[0].rad;
					circle_major_scale <= pending_pairs[0].rs;
					circle_first <= pending_pairs[0].cf;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		manifold_t e;
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_manifolds.size() == 0) begin
					$error("result with no pending prediction");
					failed = 1'b1;
				end else begin
					e = expected_manifolds.pop_front();
					if (hit !== e.hit) begin
						$error("hit exp %0d got %0d", e.hit, hit); failed = 1'b1;
					end
					if (point_a_x !== e.ax) begin
						$error("point_a_x exp %0d got %0d", e.ax, point_a_x); failed = 1'b1;
					end
					if (point_a_y !== e.ay) begin
						$error("point_a_y exp %0d got %0d", e.ay, point_a_y); failed = 1'b1;
					end
					if (point_b_x !== e.bx) begin
						$error("point_b_x exp %0d got %0d", e.bx, point_b_x); failed = 1'b1;
					end
					if (point_b_y !== e.by) begin
						$error("point_b_y exp %0d got %0d", e.by, point_b_y); failed = 1'b1;
					end
					if (normal_x !== e.nx) begin
						$error("normal_x exp %0d got %0d", e.nx, normal_x); failed = 1'b1;
					end
					if (normal_y !== e.ny) begin
						$error("normal_y exp %0d got %0d", e.ny, normal_y); failed = 1'b1;
					end
					if (depth !== e.dep) begin
						$error("depth exp %0d got %0d", e.dep, depth); failed = 1'b1;
					end
				end
			end
			out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

endmodule
